### rtl/smd_pkg.sv
// Shared types, widths and constants of the sensor matrix debouncer.
package smd_pkg;

    localparam int ROW_W    = 3;
    localparam int COL_W    = 3;
    localparam int TIME_W   = 32;
    localparam int DEB_W    = 16;
    localparam int EVENT_W  = 2;
    localparam int COUNT_W  = 7;

    localparam int ROWS_DEF = 8;
    localparam int COLS_DEF = 8;

    localparam logic [DEB_W-1:0]   DEBOUNCE_RESET = 16'd75;
    localparam logic [COUNT_W-1:0] OCC_MAX        = 7'd64;

    localparam logic [EVENT_W-1:0] EV_NONE   = 2'd0;
    localparam logic [EVENT_W-1:0] EV_PLACED = 2'd1;
    localparam logic [EVENT_W-1:0] EV_LIFTED = 2'd2;

    typedef struct packed {
        logic              last_raw;
        logic              stable;
        logic [TIME_W-1:0] change_time;
    } cell_entry_t;

    localparam cell_entry_t CELL_RESET = '{last_raw: 1'b1, stable: 1'b1, change_time: '0};

endpackage

### rtl/smd_if.sv
// Handshake interfaces for samples, events and the debounce register.
interface smd_in_if import smd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              level;
    logic [TIME_W-1:0] now_ms;

    modport source (output valid, output row, output col, output level, output now_ms,
                    input ready);
    modport sink   (input valid, input row, input col, input level, input now_ms,
                    output ready);
endinterface

interface smd_out_if import smd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [EVENT_W-1:0] event_res;
    logic [ROW_W-1:0]   event_row;
    logic [COL_W-1:0]   event_col;
    logic [COUNT_W-1:0] occupied_count;

    modport source (output valid, output event_res, output event_row, output event_col,
                    output occupied_count, input ready);
    modport sink   (input valid, input event_res, input event_row, input event_col,
                    input occupied_count, output ready);
endinterface

interface smd_cfg_if import smd_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [DEB_W-1:0] debounce_ms;

    modport source (output valid, output debounce_ms, input ready);
    modport sink   (input valid, input debounce_ms, output ready);
endinterface

### rtl/smd_state_ram.sv
// Per-cell state memory with registered read and per-entry valid bits.
module smd_state_ram import smd_pkg::*;
#(
    parameter int DEPTH  = ROWS_DEF * COLS_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output cell_entry_t       rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  cell_entry_t       wr_data
);

    cell_entry_t       mem [DEPTH];
    cell_entry_t       rd_raw_reg;
    logic              rd_valid_reg;
    logic [DEPTH-1:0]  valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_raw_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_raw_reg : CELL_RESET;

endmodule

### rtl/sensor_matrix_debouncer.sv
// Top level of the sensor matrix debouncer: per-cell debounce and occupancy count.
// A sample is registered in the s1 stage and then in the output registers; s1 holds while events stall.
// Throughput: one sample per cycle while the event output accepts, set by the single read-modify-write
// of the cell memory, with the written entry forwarded to a following sample of the same cell.
// Reset: control, valid bits and occupancy clear at once, debounce_ms returns to 75;
// no clearing pass, a sample may be taken in the first cycle after reset.
module sensor_matrix_debouncer import smd_pkg::*;
#(
    parameter int ROWS = ROWS_DEF,
    parameter int COLS = COLS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    smd_cfg_if.sink    cfg,
    smd_in_if.sink     samples,
    smd_out_if.source  events
);

    localparam int CELLS  = ROWS * COLS;
    localparam int IDX_W  = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int PROD_W = ROW_W + COL_W + 2;

    logic [DEB_W-1:0]   debounce_reg;
    logic [COUNT_W-1:0] occupancy_reg;
    logic [COUNT_W-1:0] occupancy_next;

    logic               s1_valid_reg;
    logic [ROW_W-1:0]   s1_row_reg;
    logic [COL_W-1:0]   s1_col_reg;
    logic               s1_level_reg;
    logic [TIME_W-1:0]  s1_now_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic               s1_in_range_reg;
    logic               fwd_hit_reg;
    cell_entry_t        fwd_data_reg;

    logic               out_valid_reg;
    logic [EVENT_W-1:0] out_event_reg;
    logic [ROW_W-1:0]   out_row_reg;
    logic [COL_W-1:0]   out_col_reg;
    logic [COUNT_W-1:0] out_count_reg;

    logic               in_take;
    logic               in_range;
    logic [PROD_W-1:0]  in_sum;
    logic [IDX_W-1:0]   in_idx;
    logic               s1_adv;
    logic               s1_wr;
    cell_entry_t        ram_rd;
    cell_entry_t        cur;
    cell_entry_t        entry_next;
    logic [TIME_W-1:0]  ct;
    logic [TIME_W-1:0]  elapsed;
    logic               take;
    logic [EVENT_W-1:0] event_next;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= DEBOUNCE_RESET;
        end
        else if (cfg.valid)
        begin
            debounce_reg <= cfg.debounce_ms;
        end
    end

    // decode the cell address
    assign in_range = (int'(samples.row) < ROWS) && (int'(samples.col) < COLS);
    assign in_sum   = PROD_W'(samples.row) * PROD_W'(COLS) + PROD_W'(samples.col);
    assign in_idx   = in_sum[IDX_W-1:0];

    assign s1_adv        = s1_valid_reg && (!out_valid_reg || events.ready);
    assign s1_wr         = s1_adv && s1_in_range_reg;
    assign samples.ready = !s1_valid_reg || s1_adv;
    assign in_take       = samples.valid && samples.ready;

    smd_state_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (IDX_W)
    ) u_state_ram (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_take),
        .rd_addr (in_idx),
        .rd_data (ram_rd),
        .wr_en   (s1_wr),
        .wr_addr (s1_idx_reg),
        .wr_data (entry_next)
    );

    // update the cell entry and the count
    always_comb
    begin
        cur     = fwd_hit_reg ? fwd_data_reg : ram_rd;
        ct      = (cur.last_raw != s1_level_reg) ? s1_now_reg : cur.change_time;
        elapsed = s1_now_reg - ct;
        take    = (elapsed > TIME_W'(debounce_reg)) && (s1_level_reg != cur.stable);
        entry_next.last_raw    = s1_level_reg;
        entry_next.stable      = take ? s1_level_reg : cur.stable;
        entry_next.change_time = ct;
        event_next     = EV_NONE;
        occupancy_next = occupancy_reg;
        if (s1_in_range_reg && take)
        begin
            if (!s1_level_reg)
            begin
                event_next = EV_PLACED;
                if (occupancy_reg < OCC_MAX)
                begin
                    occupancy_next = occupancy_reg + 1'b1;
                end
            end
            else
            begin
                event_next = EV_LIFTED;
                if (occupancy_reg != '0)
                begin
                    occupancy_next = occupancy_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            occupancy_reg <= '0;
        end
        else
        begin
            if (in_take)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= s1_wr && (s1_idx_reg == in_idx);
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
                occupancy_reg <= occupancy_next;
            end
            else if (events.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_row_reg      <= samples.row;
            s1_col_reg      <= samples.col;
            s1_level_reg    <= samples.level;
            s1_now_reg      <= samples.now_ms;
            s1_idx_reg      <= in_idx;
            s1_in_range_reg <= in_range;
            fwd_data_reg    <= entry_next;
        end
        if (s1_adv)
        begin
            out_event_reg <= event_next;
            out_row_reg   <= s1_row_reg;
            out_col_reg   <= s1_col_reg;
            out_count_reg <= occupancy_next;
        end
    end

    assign events.valid          = out_valid_reg;
    assign events.event_res      = out_event_reg;
    assign events.event_row      = out_row_reg;
    assign events.event_col      = out_col_reg;
    assign events.occupied_count = out_count_reg;

endmodule

### tb/tb_sensor_matrix_debouncer.sv
// Self-checking testbench of the sensor matrix debouncer: directed and random cell samples against a predictor.
`timescale 1ns / 1ps

module tb_sensor_matrix_debouncer;
    import smd_pkg::*;

    typedef struct {
        logic [EVENT_W-1:0] ev;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   col;
        logic [COUNT_W-1:0] count;
    } cell_event_t;

    typedef enum {MIX_CELLS, FILL_BOARD, CLEAR_BOARD} phase_mode_t;

    localparam int CELLS = ROWS_DEF * COLS_DEF;

    class debounce_board;
        logic              raw_seen [CELLS];
        logic              settled [CELLS];
        logic [TIME_W-1:0] changed_at [CELLS];
        logic [COUNT_W-1:0] occupancy;
        logic [DEB_W-1:0]  debounce;
        cell_event_t       pending_events[$];
        int                errors;
        int                taken;

        function new();
            for (int i = 0; i < CELLS; i++)
            begin
                raw_seen[i]   = 1'b1;
                settled[i]    = 1'b1;
                changed_at[i] = '0;
            end
            occupancy = '0;
            debounce  = DEBOUNCE_RESET;
            errors    = 0;
            taken     = 0;
        endfunction

        function void note_sample(logic [ROW_W-1:0] row, logic [COL_W-1:0] col, logic lvl,
                                  logic [TIME_W-1:0] now);
            cell_event_t       exp_ev;
            int                idx;
            logic [TIME_W-1:0] elapsed;
            exp_ev.ev  = EV_NONE;
            exp_ev.row = row;
            exp_ev.col = col;
            taken++;
            if (int'(row) < ROWS_DEF && int'(col) < COLS_DEF)
            begin
                idx = int'(row) * COLS_DEF + int'(col);
                if (raw_seen[idx] != lvl)
                    changed_at[idx] = now;
                elapsed = now - changed_at[idx];
                if (elapsed > {16'd0, debounce} && lvl != settled[idx])
                begin
                    settled[idx] = lvl;
                    if (lvl == 1'b0)
                    begin
                        exp_ev.ev = EV_PLACED;
                        if (occupancy < OCC_MAX)
                            occupancy++;
                    end
                    else
                    begin
                        exp_ev.ev = EV_LIFTED;
                        if (occupancy > 0)
                            occupancy--;
                    end
                end
                raw_seen[idx] = lvl;
            end
            exp_ev.count = occupancy;
            pending_events.push_back(exp_ev);
        endfunction

        function void check_event(logic [EVENT_W-1:0] ev, logic [ROW_W-1:0] row,
                                  logic [COL_W-1:0] col, logic [COUNT_W-1:0] count);
            cell_event_t exp_ev;
            if (pending_events.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected event: ev %0d row %0d col %0d count %0d",
                             ev, row, col, count);
                return;
            end
            exp_ev = pending_events.pop_front();
            if (ev !== exp_ev.ev || row !== exp_ev.row || col !== exp_ev.col ||
                count !== exp_ev.count)
            begin
                errors++;
                if (errors <= 10)
                    $display("event mismatch: expected ev %0d row %0d col %0d count %0d, %s",
                             exp_ev.ev, exp_ev.row, exp_ev.col, exp_ev.count,
                             $sformatf("got ev %0d row %0d col %0d count %0d",
                                       ev, row, col, count));
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic calm;
    logic hold_off;
    logic [TIME_W-1:0] clock_ms;
    logic target_level [CELLS];

    debounce_board board = new();

    smd_cfg_if cfg_ch();
    smd_in_if  sample_ch();
    smd_out_if event_ch();

    sensor_matrix_debouncer dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .samples (sample_ch),
        .events  (event_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            event_ch.ready <= 1'b0;
        else
        begin
            if (event_ch.valid && event_ch.ready)
                board.check_event(event_ch.event_res, event_ch.event_row, event_ch.event_col,
                                  event_ch.occupied_count);
            event_ch.ready <= !hold_off && (calm || $urandom_range(0, 99) >= 22);
        end
    end

    // hold the event side back long enough to back the samples up
    initial
    begin
        int held;
        hold_off <= 1'b0;
        do
            @(posedge clk);
        while (board.taken < 1150);
        hold_off <= 1'b1;
        for (held = 0; held < 250; held++)
            @(posedge clk);
        hold_off <= 1'b0;
    end

    task automatic send_sample(input int row, input int col, input logic lvl,
                               input logic [TIME_W-1:0] now);
        int gap;
        gap = 0;
        while (!calm && $urandom_range(0, 99) < 22)
            gap++;
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.row    <= ROW_W'(row);
        sample_ch.col    <= COL_W'(col);
        sample_ch.level  <= lvl;
        sample_ch.now_ms <= now;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        board.note_sample(ROW_W'(row), COL_W'(col), lvl, now);
    endtask

    task automatic wait_idle();
        sample_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending_events.size() != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_debounce(input logic [DEB_W-1:0] value);
        cfg_ch.valid       <= 1'b1;
        cfg_ch.debounce_ms <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        board.debounce = value;
    endtask

    task automatic run_phase(input int n, input int subset, input phase_mode_t mode);
        int unsigned step_max;
        int          base;
        int          idx;
        int          bounce;
        logic        lvl;
        logic [TIME_W-1:0] stamp;
        base     = $urandom_range(0, CELLS - 1);
        step_max = (int'(board.debounce) * 3) / subset + 1;
        bounce   = (mode == MIX_CELLS) ? 12 : 3;
        clock_ms = $urandom;
        for (int i = 0; i < n; i++)
        begin
            if (mode == MIX_CELLS)
            begin
                idx = (base + $urandom_range(0, subset - 1)) % CELLS;
                if ($urandom_range(0, 7) == 0)
                    target_level[idx] = ~target_level[idx];
            end
            else
            begin
                idx = i % CELLS;
                target_level[idx] = (mode == CLEAR_BOARD);
            end
            lvl = ($urandom_range(0, 99) < bounce) ? ~target_level[idx] : target_level[idx];
            clock_ms += $urandom_range(0, step_max);
            stamp = ($urandom_range(0, 99) < 4) ? TIME_W'($urandom) : clock_ms;
            send_sample(idx / COLS_DEF, idx % COLS_DEF, lvl, stamp);
        end
    endtask

    initial
    begin
        rst_n              <= 1'b0;
        calm               <= 1'b0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.debounce_ms <= '0;
        sample_ch.valid    <= 1'b0;
        sample_ch.row      <= '0;
        sample_ch.col      <= '0;
        sample_ch.level    <= 1'b1;
        sample_ch.now_ms   <= '0;
        for (int i = 0; i < CELLS; i++)
            target_level[i] = 1'b1;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // fresh change, equal to the debounce time, then just past it
        send_sample(0, 0, 1'b0, 32'd100);
        send_sample(0, 0, 1'b0, 32'd175);
        send_sample(0, 0, 1'b0, 32'd176);
        send_sample(0, 0, 1'b0, 32'd5000);
        // timestamp wrap on the far corner
        send_sample(7, 7, 1'b0, 32'hFFFF_FFF0);
        send_sample(7, 7, 1'b0, 32'h0000_0040);
        send_sample(7, 7, 1'b1, 32'h0000_0050);
        send_sample(7, 7, 1'b1, 32'h0000_009E);
        send_sample(7, 7, 1'b1, 32'h0000_009F);
        // a level matching the settled one after a long time
        send_sample(3, 4, 1'b1, 32'hFFFF_FFFF);
        // bounce restarts the timer
        send_sample(0, 7, 1'b0, 32'd1000);
        send_sample(0, 7, 1'b1, 32'd1050);
        send_sample(0, 7, 1'b0, 32'd1100);
        send_sample(0, 7, 1'b0, 32'd1170);
        send_sample(0, 7, 1'b0, 32'd1176);
        send_sample(7, 0, 1'b0, 32'd0);
        send_sample(7, 0, 1'b0, 32'd80);
        // lift back to an empty count
        send_sample(0, 0, 1'b1, 32'd6000);
        send_sample(0, 0, 1'b1, 32'd6100);
        send_sample(0, 7, 1'b1, 32'd6000);
        send_sample(0, 7, 1'b1, 32'd6100);
        send_sample(7, 0, 1'b1, 32'd6000);
        send_sample(7, 0, 1'b1, 32'd6100);
        send_sample(0, 0, 1'b1, 32'd9000);
        wait_idle();

        write_debounce(16'd0);
        run_phase(150, 8, MIX_CELLS);
        wait_idle();
        write_debounce(16'hFFFF);
        run_phase(150, 4, MIX_CELLS);
        wait_idle();
        calm <= 1'b1;
        write_debounce(16'd3);
        run_phase(150, 2, MIX_CELLS);
        wait_idle();
        calm <= 1'b0;
        write_debounce(DEB_W'($urandom));
        run_phase(150, 16, MIX_CELLS);
        wait_idle();
        write_debounce(16'd10);
        run_phase(256, CELLS, FILL_BOARD);
        run_phase(256, CELLS, CLEAR_BOARD);
        wait_idle();
        write_debounce(DEBOUNCE_RESET);
        run_phase(150, CELLS, MIX_CELLS);
        wait_idle();
        write_debounce(DEB_W'($urandom_range(0, 200)));
        run_phase(150, 1, MIX_CELLS);
        wait_idle();

        if (board.errors == 0 && board.pending_events.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
